// ----- sv/pdsp_pkg.sv -----
// shared constants, payload and control types of the periodic-departure path unit
package pdsp_pkg;

  localparam int MaxNodes  = 1024;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int NcW       = NodeW + 1;
  localparam int MaxEdges  = 4096;
  localparam int EdgeAw    = $clog2(MaxEdges);
  localparam int EdgeCntW  = EdgeAw + 1;
  localparam int TimeW     = 32;
  localparam int ArrW      = 48;
  localparam int NodeRamW  = ArrW + 2;
  localparam int EndsW     = 2 * NodeW;
  localparam int DivCntW   = $clog2(ArrW);
  localparam int PaddrW    = 4;

  localparam logic [1:0] RegNodeCount  = 2'd0;
  localparam logic [1:0] RegSourceNode = 2'd1;
  localparam logic [1:0] RegTargetNode = 2'd2;

  localparam logic [NcW-1:0] NcMax = NcW'(MaxNodes);
  localparam logic [ArrW-1:0] ArrMax = {ArrW{1'b1}};

  typedef struct packed {
    logic [NodeW-1:0] end_a;
    logic [NodeW-1:0] end_b;
    logic [TimeW-1:0] travel_time;
    logic [TimeW-1:0] depart_period;
    logic             last_edge;
  } in_t;

  typedef struct packed {
    logic            reachable;
    logic [ArrW-1:0] arrival_time;
    logic            edge_overflow;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SEED,
    S_SCAN,
    S_SCAN_END,
    S_PICK,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_NODE_CHK,
    S_DIV,
    S_ADD,
    S_RELAX,
    S_TGT_RD,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic node_clr_wr;
    logic seed_wr;
    logic idx_clr;
    logic idx_inc;
    logic scan_rd;
    logic best_clr;
    logic settle_wr;
    logic eidx_clr;
    logic eidx_inc;
    logic node_rd_to;
    logic div_start;
    logic dep_calc;
    logic relax_wr;
    logic tgt_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic src_ok;
    logic found;
    logic edge_end;
    logic edge_hit;
    logic to_settled;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/pdsp_ram.sv -----
// generic single-write, single-read ram with registered read
module pdsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/pdsp_div.sv -----
// bit-serial remainder unit, one dividend bit per cycle
module pdsp_div
  import pdsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ArrW-1:0]  dividend_i,
  input  logic [TimeW-1:0] divisor_i,
  output logic             done_o,
  output logic [TimeW-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [ArrW-1:0]    dvd_q, dvd_d;
  logic [TimeW-1:0]   rem_q, rem_d;
  logic [TimeW-1:0]   dvs_q, dvs_d;
  logic [TimeW:0]     trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, dvd_q[ArrW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = (divisor_i == '0) ? TimeW'(1) : divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        trial = trial - {1'b0, dvs_q};
      end
      rem_d = trial[TimeW-1:0];
      dvd_d = {dvd_q[ArrW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(ArrW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/pdsp_datapath.sv -----
// edge and node memories, scan registers, relaxation arithmetic and result register
module pdsp_datapath
  import pdsp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  in_t              in_data_i,
  input  logic [NcW-1:0]   nc_i,
  input  logic [NodeW-1:0] src_i,
  input  logic [NodeW-1:0] tgt_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output out_t             out_data_o
);

  logic [EdgeCntW-1:0] etot_q, etot_d;
  logic                drop_q, drop_d;
  logic [NodeW-1:0]    idx_q, idx_d;
  logic [EdgeCntW-1:0] eidx_q, eidx_d;
  logic                scan_v_q;
  logic [NodeW-1:0]    scan_idx_q;
  logic                found_q, found_d;
  logic [NodeW-1:0]    best_q, best_d;
  logic [ArrW-1:0]     best_arr_q, best_arr_d;
  logic [NodeW-1:0]    to_q;
  logic [TimeW-1:0]    per_q;
  logic [TimeW-1:0]    trv_q;
  logic [ArrW-1:0]     to_arr_q;
  logic                to_reached_q;
  logic [ArrW:0]       dep_q;
  logic                out_v_q, out_v_d;
  out_t                out_q;

  logic                in_ok;
  logic [EndsW-1:0]    ends_rd;
  logic [TimeW-1:0]    trv_rd, per_rd;
  logic [NodeW-1:0]    ea, eb, to_c;
  logic                e_rng;
  logic [NodeRamW-1:0] node_rd, node_wd;
  logic                node_we, node_re;
  logic [NodeW-1:0]    node_wa, node_ra;
  logic                div_done;
  logic [TimeW-1:0]    rem;
  logic [TimeW-1:0]    per_eff;
  logic [ArrW+1:0]     arr_sum;
  logic [ArrW-1:0]     cand;
  logic                relax_ok;
  logic                tgt_ok;

  assign in_ok = ({1'b0, in_data_i.end_a} < nc_i) && ({1'b0, in_data_i.end_b} < nc_i)
                 && (etot_q < EdgeCntW'(MaxEdges));

  pdsp_ram #(.Width(EndsW), .Depth(MaxEdges)) u_ends (
    .clk_i, .we_i(cmd_i.load && in_ok), .waddr_i(etot_q[EdgeAw-1:0]),
    .wdata_i({in_data_i.end_b, in_data_i.end_a}), .re_i(1'b1),
    .raddr_i(eidx_q[EdgeAw-1:0]), .rdata_o(ends_rd)
  );
  pdsp_ram #(.Width(TimeW), .Depth(MaxEdges)) u_travel (
    .clk_i, .we_i(cmd_i.load && in_ok), .waddr_i(etot_q[EdgeAw-1:0]),
    .wdata_i(in_data_i.travel_time), .re_i(1'b1),
    .raddr_i(eidx_q[EdgeAw-1:0]), .rdata_o(trv_rd)
  );
  pdsp_ram #(.Width(TimeW), .Depth(MaxEdges)) u_period (
    .clk_i, .we_i(cmd_i.load && in_ok), .waddr_i(etot_q[EdgeAw-1:0]),
    .wdata_i(in_data_i.depart_period), .re_i(1'b1),
    .raddr_i(eidx_q[EdgeAw-1:0]), .rdata_o(per_rd)
  );

  // node word: reached, settled, arrival
  pdsp_ram #(.Width(NodeRamW), .Depth(MaxNodes)) u_nodes (
    .clk_i, .we_i(node_we), .waddr_i(node_wa), .wdata_i(node_wd),
    .re_i(node_re), .raddr_i(node_ra), .rdata_o(node_rd)
  );

  assign per_eff = (per_q == '0) ? TimeW'(1) : per_q;

  pdsp_div u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .dividend_i(best_arr_q),
    .divisor_i(per_eff), .done_o(div_done), .rem_o(rem)
  );

  assign ea    = ends_rd[NodeW-1:0];
  assign eb    = ends_rd[EndsW-1:NodeW];
  assign e_rng = ({1'b0, ea} < nc_i) && ({1'b0, eb} < nc_i);
  assign to_c  = (ea == best_q) ? eb : ea;

  assign arr_sum  = {1'b0, dep_q} + (ArrW+2)'(trv_q);
  assign cand     = (arr_sum > (ArrW+2)'(ArrMax)) ? ArrMax : arr_sum[ArrW-1:0];
  assign relax_ok = !to_reached_q || (cand < to_arr_q);
  assign tgt_ok   = ({1'b0, tgt_i} < nc_i) && node_rd[NodeRamW-1];

  always_comb begin
    node_we = 1'b0;
    node_wa = idx_q;
    node_wd = '0;
    if (cmd_i.node_clr_wr) begin
      node_we = 1'b1;
    end else if (cmd_i.seed_wr) begin
      node_we = 1'b1;
      node_wa = src_i;
      node_wd = {1'b1, 1'b0, ArrW'(0)};
    end else if (cmd_i.settle_wr) begin
      node_we = 1'b1;
      node_wa = best_q;
      node_wd = {1'b1, 1'b1, best_arr_q};
    end else if (cmd_i.relax_wr && relax_ok) begin
      node_we = 1'b1;
      node_wa = to_q;
      node_wd = {1'b1, 1'b0, cand};
    end
  end

  always_comb begin
    node_re = cmd_i.scan_rd || cmd_i.node_rd_to || cmd_i.tgt_rd;
    node_ra = idx_q;
    if (cmd_i.node_rd_to) begin
      node_ra = to_c;
    end else if (cmd_i.tgt_rd) begin
      node_ra = tgt_i;
    end
  end

  always_comb begin
    etot_d     = etot_q;
    drop_d     = drop_q;
    idx_d      = idx_q;
    eidx_d     = eidx_q;
    found_d    = found_q;
    best_d     = best_q;
    best_arr_d = best_arr_q;
    out_v_d    = out_v_q;
    if (cmd_i.load) begin
      if (in_ok) begin
        etot_d = etot_q + 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.eidx_clr) begin
      eidx_d = '0;
    end else if (cmd_i.eidx_inc) begin
      eidx_d = eidx_q + 1'b1;
    end
    if (cmd_i.best_clr) begin
      found_d = 1'b0;
    end else if (scan_v_q && node_rd[NodeRamW-1] && !node_rd[NodeRamW-2]
                 && (!found_q || node_rd[ArrW-1:0] < best_arr_q)) begin
      found_d    = 1'b1;
      best_d     = scan_idx_q;
      best_arr_d = node_rd[ArrW-1:0];
    end
    if (out_v_q && !out_stall_i) begin
      out_v_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_v_d = 1'b1;
      etot_d  = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      etot_q   <= '0;
      drop_q   <= 1'b0;
      idx_q    <= '0;
      eidx_q   <= '0;
      scan_v_q <= 1'b0;
      found_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      etot_q   <= etot_d;
      drop_q   <= drop_d;
      idx_q    <= idx_d;
      eidx_q   <= eidx_d;
      scan_v_q <= cmd_i.scan_rd;
      found_q  <= found_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= idx_q;
    best_q     <= best_d;
    best_arr_q <= best_arr_d;
    if (cmd_i.node_rd_to) begin
      to_q  <= to_c;
      per_q <= per_rd;
      trv_q <= trv_rd;
    end
    if (cmd_i.div_start) begin
      to_arr_q     <= node_rd[ArrW-1:0];
      to_reached_q <= node_rd[NodeRamW-1];
    end
    if (cmd_i.dep_calc) begin
      dep_q <= (rem == '0) ? {1'b0, best_arr_q}
                           : {1'b0, best_arr_q} + (ArrW+1)'(per_eff - rem);
    end
    if (cmd_i.out_load) begin
      out_q.reachable     <= tgt_ok;
      out_q.arrival_time  <= tgt_ok ? node_rd[ArrW-1:0] : '0;
      out_q.edge_overflow <= drop_q;
    end
  end

  assign sts_o.idx_last   = ({1'b0, idx_q} == nc_i - 1'b1);
  assign sts_o.src_ok     = ({1'b0, src_i} < nc_i);
  assign sts_o.found      = found_q;
  assign sts_o.edge_end   = (eidx_q >= etot_q);
  assign sts_o.edge_hit   = e_rng && ((ea == best_q) || (eb == best_q));
  assign sts_o.to_settled = node_rd[NodeRamW-2];
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_v_q || !out_stall_i;

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/pdsp_ctrl.sv -----
// search sequencer state machine
module pdsp_ctrl
  import pdsp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_last_i) begin
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (sts_i.idx_last) begin
          state_d = S_SEED;
        end
      end
      S_SEED: state_d = S_SCAN;
      S_SCAN: begin
        if (sts_i.idx_last) begin
          state_d = S_SCAN_END;
        end
      end
      S_SCAN_END: state_d = S_PICK;
      S_PICK: state_d = sts_i.found ? S_EDGE_RD : S_TGT_RD;
      S_EDGE_RD: state_d = sts_i.edge_end ? S_SCAN : S_EDGE_CHK;
      S_EDGE_CHK: state_d = sts_i.edge_hit ? S_NODE_CHK : S_EDGE_RD;
      S_NODE_CHK: state_d = sts_i.to_settled ? S_EDGE_RD : S_DIV;
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_ADD;
        end
      end
      S_ADD: state_d = S_RELAX;
      S_RELAX: state_d = S_EDGE_RD;
      S_TGT_RD: state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load    = in_valid_i;
        cmd_o.idx_clr = 1'b1;
      end
      S_CLEAR: begin
        cmd_o.node_clr_wr = 1'b1;
        cmd_o.idx_inc     = 1'b1;
        cmd_o.idx_clr     = sts_i.idx_last;
      end
      S_SEED: begin
        cmd_o.seed_wr  = sts_i.src_ok;
        cmd_o.idx_clr  = 1'b1;
        cmd_o.best_clr = 1'b1;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.idx_inc = 1'b1;
        cmd_o.idx_clr = sts_i.idx_last;
      end
      S_SCAN_END: cmd_o.idx_clr = 1'b1;
      S_PICK: begin
        cmd_o.settle_wr = sts_i.found;
        cmd_o.eidx_clr  = 1'b1;
      end
      S_EDGE_RD: begin
        cmd_o.best_clr = sts_i.edge_end;
        cmd_o.idx_clr  = 1'b1;
      end
      S_EDGE_CHK: begin
        cmd_o.node_rd_to = sts_i.edge_hit;
        cmd_o.eidx_inc   = !sts_i.edge_hit;
      end
      S_NODE_CHK: begin
        cmd_o.div_start = !sts_i.to_settled;
        cmd_o.eidx_inc  = sts_i.to_settled;
      end
      S_DIV: ;
      S_ADD: cmd_o.dep_calc = 1'b1;
      S_RELAX: begin
        cmd_o.relax_wr = 1'b1;
        cmd_o.eidx_inc = 1'b1;
      end
      S_TGT_RD: cmd_o.tgt_rd = 1'b1;
      S_OUT: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE)
    else $error("edge written outside idle");

  a_relax_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RELAX |=> state_q == S_EDGE_RD)
    else $error("relax not followed by next edge");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result overwrites pending transfer");

endmodule

// ----- sv/periodic_departure_shortest_path_unit.sv -----
// top level of the periodic-departure earliest-arrival search unit
//
// edges arrive on the input channel, one transfer per cycle while idle;
// each edge is written into edge memory in the cycle it is taken
// the transfer with last_edge set starts the search; the input stalls
// until the result has been placed in the output register
// the search time, with the output register free, is set by the node
// clearing sweep, the node scans, the edge walks and the bit-serial
// remainder unit of each relaxation
// one result transfer follows each search; a stalled result holds,
// and new edges are taken while it waits
// node state is cleared by a sweep over all nc nodes at each search start, where nc is the node count
// after reset: node_count 1, source and target 0, edge memory empty
// registers are written over the apb port only while idle; the user must keep to this, the block does not enforce it
module periodic_departure_shortest_path_unit
  import pdsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [NcW-1:0]   node_count_q;
  logic [NodeW-1:0] source_q;
  logic [NodeW-1:0] target_q;
  logic [NcW-1:0]   nc;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NcW'(1);
      source_q     <= '0;
      target_q     <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegNodeCount:  node_count_q <= pwdata[NcW-1:0];
        RegSourceNode: source_q     <= pwdata[NodeW-1:0];
        RegTargetNode: target_q     <= pwdata[NodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegNodeCount:  prdata = 32'(node_count_q);
      RegSourceNode: prdata = 32'(source_q);
      RegTargetNode: prdata = 32'(target_q);
      default:       prdata = '0;
    endcase
  end

  assign nc = (node_count_q == '0) ? NcW'(1)
            : (node_count_q > NcMax) ? NcMax : node_count_q;

  pdsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_last_i(in_data_i.last_edge),
    .in_stall_o, .sts_i(sts), .cmd_o(cmd)
  );

  pdsp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_data_i, .nc_i(nc),
    .src_i(source_q), .tgt_i(target_q), .out_stall_i, .out_valid_o, .out_data_o
  );

endmodule

// ----- verif/tb_top.sv -----
// testbench for the periodic-departure shortest path unit: directed table plus random graphs
`timescale 1ns / 1ps

module tb_top;
  import pdsp_pkg::*;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  in_t               in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_t              out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  periodic_departure_shortest_path_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int          errors = 0;
  longint      cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  out_t        route_q[$];

  // predictor state
  int          g_nc = 1, g_src = 0, g_tgt = 0;
  logic [10:0] g_nc_raw = 11'd1;
  int          g_ea[$], g_eb[$];
  logic [31:0] g_tt[$], g_pp[$];
  logic        g_drop = 1'b0;

  function automatic logic [ArrW-1:0] leg_arrival(logic [ArrW-1:0] d, logic [31:0] p,
                                                  logic [31:0] t);
    logic [63:0] pp, r, a;
    pp = (p == 0) ? 64'd1 : {32'd0, p};
    r = {16'd0, d} % pp;
    a = {16'd0, d} + (r != 0 ? pp - r : 64'd0) + {32'd0, t};
    return (a > {16'd0, ArrMax}) ? ArrMax : a[ArrW-1:0];
  endfunction

  function automatic out_t earliest_route();
    logic [ArrW-1:0] arr[MaxNodes];
    bit reached[MaxNodes], done[MaxNodes];
    int best, a, b;
    logic [ArrW-1:0] c;
    out_t r;
    for (int i = 0; i < MaxNodes; i++) begin
      reached[i] = 0; done[i] = 0; arr[i] = '0;
    end
    if (g_src < g_nc) begin
      reached[g_src] = 1;
      forever begin
        best = -1;
        for (int i = 0; i < g_nc; i++)
          if (reached[i] && !done[i] && (best < 0 || arr[i] < arr[best])) best = i;
        if (best < 0) break;
        done[best] = 1;
        foreach (g_ea[e]) begin
          a = g_ea[e]; b = g_eb[e];
          if (a >= g_nc || b >= g_nc) continue;
          for (int s = 0; s < 2; s++) begin
            int f, t2;
            f = s ? b : a; t2 = s ? a : b;
            if (f != best || done[t2]) continue;
            c = leg_arrival(arr[f], g_pp[e], g_tt[e]);
            if (!reached[t2] || c < arr[t2]) begin
              arr[t2] = c; reached[t2] = 1;
            end
          end
        end
      end
    end
    r.reachable = (g_tgt < g_nc) && reached[g_tgt];
    r.arrival_time = r.reachable ? arr[g_tgt] : '0;
    r.edge_overflow = g_drop;
    return r;
  endfunction

  function automatic void load_edge(in_t it);
    if (it.end_a >= g_nc || it.end_b >= g_nc || g_ea.size() >= MaxEdges) begin
      g_drop = 1'b1;
    end else begin
      g_ea.push_back(int'(it.end_a)); g_eb.push_back(int'(it.end_b));
      g_tt.push_back(it.travel_time); g_pp.push_back(it.depart_period);
    end
    if (it.last_edge) begin
      route_q.push_back(earliest_route());
      g_ea.delete(); g_eb.delete(); g_tt.delete(); g_pp.delete();
      g_drop = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 64'd20_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (route_q.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        out_t x;
        x = route_q.pop_front();
        if (out_data_o.reachable !== x.reachable) begin
          $error("reachable exp %0d got %0d", x.reachable, out_data_o.reachable); errors++;
        end
        if (out_data_o.arrival_time !== x.arrival_time) begin
          $error("arrival_time exp %0h got %0h", x.arrival_time, out_data_o.arrival_time);
          errors++;
        end
        if (out_data_o.edge_overflow !== x.edge_overflow) begin
          $error("edge_overflow exp %0d got %0d", x.edge_overflow, out_data_o.edge_overflow);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= PaddrW'(4 * idx); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegNodeCount: begin
        g_nc_raw = val[10:0];
        g_nc = (g_nc_raw == 0) ? 1 : (g_nc_raw > MaxNodes ? MaxNodes : int'(g_nc_raw));
      end
      RegSourceNode: g_src = int'(val[9:0]);
      RegTargetNode: g_tgt = int'(val[9:0]);
      default: ;
    endcase
  endtask

  // valid stays high after the transfer until the next call or drain decides
  task automatic send_raw(in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_edge(in_t it);
    send_raw(it);
    load_edge(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_t edge_of(int a, int b, logic [31:0] t, logic [31:0] p, bit l);
    in_t it;
    it.end_a = NodeW'(a); it.end_b = NodeW'(b);
    it.travel_time = t; it.depart_period = p; it.last_edge = l;
    return it;
  endfunction

  function automatic in_t rand_edge(int span, bit l);
    logic [31:0] t, p;
    t = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(20);
    case ($urandom_range(4))
      0: p = $urandom();
      1: p = 0;
      default: p = $urandom_range(1, 9);
    endcase
    return edge_of($urandom_range(span - 1), $urandom_range(span - 1), t, p, l);
  endfunction

  typedef struct {
    in_t  it;
    bit   has_exp;
    out_t exp_r;
  } row_t;

  initial begin
    row_t rows[$];
    int n, span;
    // node_count 4, source 0, target 3
    rows.push_back('{edge_of(0, 1, 5, 1, 0), 0, '0});
    rows.push_back('{edge_of(1, 3, 2, 4, 1), 1, '{1'b1, 48'd10, 1'b0}});
    rows.push_back('{edge_of(0, 3, 7, 0, 1), 1, '{1'b1, 48'd7, 1'b0}});
    rows.push_back('{edge_of(0, 1, 1, 1, 1), 1, '{1'b0, 48'd0, 1'b0}});
    rows.push_back('{edge_of(0, 9, 1, 1, 0), 0, '0});
    rows.push_back('{edge_of(1023, 0, 1, 1, 0), 0, '0});
    rows.push_back('{edge_of(0, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 1,
                     '{1'b1, 48'hFFFF_FFFF, 1'b1}});
    rows.push_back('{edge_of(0, 1, 32'hFFFF_FFFF, 1, 0), 0, '0});
    rows.push_back('{edge_of(1, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 0, '0});
    rows.push_back('{edge_of(2, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1), 0, '0});
    rows.push_back('{edge_of(3, 3, 0, 3, 1), 1, '{1'b0, 48'd0, 1'b0}});
    rows.push_back('{edge_of(2, 1, 3, 3, 0), 0, '0});
    rows.push_back('{edge_of(0, 2, 4, 2, 1), 0, '0});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    reg_write(RegNodeCount, 4);
    reg_write(RegSourceNode, 0);
    reg_write(RegTargetNode, 3);
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        load_edge(rows[i].it);
        void'(route_q.pop_back());
        route_q.push_back(rows[i].exp_r);
        rows[i].it.last_edge = 1'b1;
        // send without second prediction
        send_raw(rows[i].it);
      end else begin
        send_edge(rows[i].it);
      end
    end
    drain();
    // node count lowered after loading, target out of range
    send_edge(edge_of(0, 3, 1, 1, 0));
    drain();
    reg_write(RegNodeCount, 2);
    send_edge(edge_of(0, 1, 1, 1, 1));
    drain();
    reg_write(RegNodeCount, 0);
    reg_write(RegTargetNode, 1023);
    send_edge(edge_of(0, 0, 1, 1, 1));
    drain();
    reg_write(RegNodeCount, 1024);
    reg_write(RegSourceNode, 1023);
    send_edge(edge_of(1023, 512, 32'h5555_5555, 32'hAAAA_AAAA, 1));
    drain();
    reg_write(RegNodeCount, 11'h7FF);
    send_edge(edge_of(1023, 341, 32'hAAAA_AAAA, 32'h5555_5555, 1));
    drain();
    // edge memory overflow
    reg_write(RegNodeCount, 3);
    reg_write(RegSourceNode, 0);
    reg_write(RegTargetNode, 2);
    for (int k = 0; k <= MaxEdges; k++) send_edge(rand_edge(3, k == MaxEdges));
    drain();

    n = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1 ? 69 : 0);
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1 ? 37 : 0);
      while (n < (ph + 1) * 170) begin
        span = ($urandom_range(9) == 0) ? $urandom_range(20, 1024) : $urandom_range(1, 8);
        drain();
        reg_write(RegNodeCount, ($urandom_range(9) == 0) ? span + 1 : span);
        reg_write(RegSourceNode, $urandom_range(span - 1));
        reg_write(RegTargetNode, $urandom_range(9) == 0 ? $urandom_range(1023)
                                                       : $urandom_range(span - 1));
        repeat ($urandom_range(1, 12)) begin
          send_edge(rand_edge(($urandom_range(15) == 0) ? 1024 : span, 0));
          n++;
        end
        send_edge(rand_edge(span, 1));
        n++;
      end
    end
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/pdsp_pkg.sv
sv/pdsp_ram.sv
sv/pdsp_div.sv
sv/pdsp_datapath.sv
sv/pdsp_ctrl.sv
sv/periodic_departure_shortest_path_unit.sv
verif/tb_top.sv
